FILE: sv/assert_macros.svh
// Assertion macros used by the record framer sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define TRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk outside reset.
`define TRF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: sv/trf_pkg.sv
// Types and constants shared by the telemetry record framer.
`default_nettype none

package trf_pkg;

  localparam int unsigned MAX_RECORD_WORDS_DEF = 16;
  localparam int unsigned HDR_WORDS            = 3;
  localparam int unsigned MIN_LEN              = 4;
  localparam logic [4:0]  RW_RESET             = 5'd16;

  localparam logic [31:0] HDR0_WORD    = 32'hEB90_0000;
  localparam logic [7:0]  HDR1_TAG     = 8'h1F;
  localparam logic [7:0]  HDR2_TAG     = 8'h20;
  localparam logic [31:0] TIME_BASE    = 32'h4000_0000;
  localparam logic [31:0] DISCARD_WORD = 32'hBE00_0000;
  localparam logic [31:0] SPARE_WORD   = 32'hC000_0000;
  localparam logic [15:0] PH_MAX       = 16'h3FFF;
  localparam logic [31:0] TICKS_MAX    = 32'h3FFF_FFFF;

  localparam logic [1:0]  STEP_TIME    = 2'd0;
  localparam logic [1:0]  STEP_DISCARD = 2'd1;
  localparam logic [1:0]  STEP_SPARE   = 2'd2;

  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_FRAME = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_CLOSE,
    ST_FAULT
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] word;
    logic        eor;
    logic        eorun;
    logic        fault;
  } emit_t;

endpackage

`default_nettype wire

FILE: sv/telemetry_record_framer_top.sv
// Top level of the telemetry record framer.
//
//   port group     dir   handshake            payload
//   input item     in    in_valid/in_ready    opcode, pulse_height, y_index, x_index,
//                                             frame_ticks
//   result item    out   out_valid/out_ready  record_word, end_of_record, end_of_run,
//                                             fault
//   configuration  in    cfg_write            record_words
//
// A close streams one record word per cycle for the record length, paced by the single
// read port of the store; a frame end appends three words and closes. Reset (rst,
// synchronous) clears counters and rewinds fill to the header size; the store holds no
// reset value. A stalled output holds the sequencer in its close or fault state; no item
// is taken until the prior one ends.
`default_nettype none

module telemetry_record_framer_top import trf_pkg::*; #(
  parameter int unsigned MAX_RECORD_WORDS = MAX_RECORD_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [4:0]  record_words,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [15:0] pulse_height,
  input  wire logic [7:0]  y_index,
  input  wire logic [7:0]  x_index,
  input  wire logic [31:0] frame_ticks,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      record_word,
  output logic             end_of_record,
  output logic             end_of_run,
  output logic             fault
);

  localparam int unsigned ADDR_W = $clog2(MAX_RECORD_WORDS);

  emit_t             emit;
  logic              can_emit;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [31:0]       mem_rdata;

  trf_store #(
    .MAX_WORDS (MAX_RECORD_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  trf_seq #(
    .MAX_WORDS (MAX_RECORD_WORDS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .record_words (record_words),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .pulse_height (pulse_height),
    .y_index      (y_index),
    .x_index      (x_index),
    .frame_ticks  (frame_ticks),
    .can_emit     (can_emit),
    .emit         (emit),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  trf_out u_out (
    .clk           (clk),
    .rst           (rst),
    .emit          (emit),
    .can_emit      (can_emit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .record_word   (record_word),
    .end_of_record (end_of_record),
    .end_of_run    (end_of_run),
    .fault         (fault)
  );

endmodule

`default_nettype wire

FILE: sv/trf_store.sv
// Record word store: one write port, one registered read port.
`default_nettype none

module trf_store import trf_pkg::*; #(
  parameter int unsigned MAX_WORDS = MAX_RECORD_WORDS_DEF,
  localparam int unsigned ADDR_W = $clog2(MAX_WORDS)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [31:0]       wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic [31:0]            rdata
);

  logic [31:0] mem [MAX_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/trf_out.sv
// Output holding register for record words.
`default_nettype none

module trf_out import trf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire emit_t emit,
  output logic       can_emit,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [31:0] record_word,
  output logic       end_of_record,
  output logic       end_of_run,
  output logic       fault
);

  assign can_emit = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      record_word   <= emit.word;
      end_of_record <= emit.eor;
      end_of_run    <= emit.eorun;
      fault         <= emit.fault;
    end
  end

endmodule

`default_nettype wire

FILE: sv/trf_seq.sv
// Sequencer: decodes items, appends words to the store, streams closed records.
`default_nettype none
`include "assert_macros.svh"

module trf_seq import trf_pkg::*; #(
  parameter int unsigned MAX_WORDS = MAX_RECORD_WORDS_DEF,
  localparam int unsigned ADDR_W = $clog2(MAX_WORDS),
  localparam int unsigned FILL_W = $clog2(MAX_WORDS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [4:0]        record_words,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        opcode,
  input  wire logic [15:0]       pulse_height,
  input  wire logic [7:0]        y_index,
  input  wire logic [7:0]        x_index,
  input  wire logic [31:0]       frame_ticks,
  input  wire logic              can_emit,
  output emit_t                  emit,
  output logic                   mem_we,
  output logic [ADDR_W-1:0]      mem_waddr,
  output logic [31:0]            mem_wdata,
  output logic [ADDR_W-1:0]      mem_raddr,
  input  wire logic [31:0]       mem_rdata
);

  localparam int unsigned CMP_W = (FILL_W > 5) ? FILL_W : 5;

  state_t            state, state_next;
  logic [4:0]        rw;
  logic [FILL_W-1:0] fill;
  logic [7:0]        rec_cnt;
  logic [7:0]        frame_num;
  op_t               op_q;
  logic [31:0]       evt_word;
  logic [31:0]       ticks_q;
  logic [1:0]        step;
  logic              final_q;
  logic [FILL_W-1:0] idx;

  logic [CMP_W-1:0]  rw_ext;
  logic [FILL_W-1:0] len;
  logic [FILL_W-1:0] used;
  logic [FILL_W:0]   cnt_full;
  logic [7:0]        elem_cnt;
  logic [FILL_W:0]   fill_inc;
  logic              is_spare;
  logic              do_close;
  logic              last_word;
  logic              in_fault;
  logic [31:0]       app_word;
  logic [31:0]       close_word;
  logic [FILL_W-1:0] idx_rd;

  assign rw_ext = CMP_W'(rw);

  always_comb begin
    if (rw_ext < CMP_W'(MIN_LEN)) begin
      len = FILL_W'(MIN_LEN);
    end else if (rw_ext > CMP_W'(MAX_WORDS)) begin
      len = FILL_W'(MAX_WORDS);
    end else begin
      len = FILL_W'(rw_ext);
    end
  end

  assign used      = (fill > len) ? len : fill;
  assign cnt_full  = {used - FILL_W'(HDR_WORDS), 1'b0};
  assign elem_cnt  = 8'(cnt_full);
  assign fill_inc  = {1'b0, fill} + (FILL_W + 1)'(1);
  assign is_spare  = (op_q == OP_FRAME) && (step == STEP_SPARE);
  assign do_close  = is_spare || (fill_inc >= {1'b0, len});
  assign last_word = (idx == len - FILL_W'(1));
  assign in_fault  = ((op_t'(opcode) == OP_EVENT) && (pulse_height > PH_MAX)) ||
                     ((op_t'(opcode) == OP_FRAME) && (frame_ticks > TICKS_MAX));

  always_comb begin
    if (op_q == OP_EVENT) begin
      app_word = evt_word;
    end else if (step == STEP_TIME) begin
      app_word = TIME_BASE + ticks_q;
    end else if (step == STEP_DISCARD) begin
      app_word = DISCARD_WORD;
    end else begin
      app_word = SPARE_WORD;
    end
  end

  always_comb begin
    priority if (idx == FILL_W'(0)) begin
      close_word = HDR0_WORD;
    end else if (idx == FILL_W'(1)) begin
      close_word = {16'h0000, rec_cnt, HDR1_TAG};
    end else if (idx == FILL_W'(2)) begin
      close_word = {HDR2_TAG, elem_cnt, 8'h00, frame_num};
    end else if (idx < used) begin
      close_word = mem_rdata;
    end else begin
      close_word = 32'h0000_0000;
    end
  end

  assign idx_rd = (can_emit && !last_word) ? idx + FILL_W'(1) : idx;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_fault) begin
            state_next = ST_FAULT;
          end else if (op_t'(opcode) == OP_EVENT || op_t'(opcode) == OP_FRAME) begin
            state_next = ST_APPEND;
          end else if (op_t'(opcode) == OP_FLUSH && fill > FILL_W'(HDR_WORDS)) begin
            state_next = ST_CLOSE;
          end
        end
      end
      ST_APPEND: begin
        if (do_close) begin
          state_next = ST_CLOSE;
        end else if (op_q == OP_EVENT) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLOSE: begin
        if (can_emit && last_word) begin
          state_next = final_q ? ST_IDLE : ST_APPEND;
        end
      end
      ST_FAULT: begin
        if (can_emit) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    emit       = '0;
    mem_we     = 1'b0;
    mem_waddr  = ADDR_W'(fill);
    mem_wdata  = app_word;
    mem_raddr  = ADDR_W'(idx_rd);
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_APPEND: begin
        mem_we = fill < FILL_W'(MAX_WORDS);
      end
      ST_CLOSE: begin
        emit.valid = can_emit;
        emit.word  = close_word;
        emit.eor   = last_word;
        emit.eorun = last_word && final_q;
      end
      ST_FAULT: begin
        emit.valid = can_emit;
        emit.eorun = 1'b1;
        emit.fault = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rw        <= RW_RESET;
      fill      <= FILL_W'(HDR_WORDS);
      rec_cnt   <= 8'd0;
      frame_num <= 8'd0;
      step      <= STEP_TIME;
      final_q   <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        rw <= record_words;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q     <= op_t'(opcode);
            evt_word <= {2'b00, pulse_height[13:0], y_index, x_index};
            ticks_q  <= frame_ticks;
            step     <= STEP_TIME;
            final_q  <= (op_t'(opcode) == OP_FLUSH);
            idx      <= '0;
          end
        end
        ST_APPEND: begin
          fill    <= FILL_W'(fill_inc);
          final_q <= (op_q == OP_EVENT) || is_spare;
          idx     <= '0;
          if (!do_close) begin
            step <= step + 2'd1;
          end
        end
        ST_CLOSE: begin
          if (can_emit) begin
            if (last_word) begin
              idx       <= '0;
              fill      <= FILL_W'(HDR_WORDS);
              rec_cnt   <= rec_cnt + 8'd1;
              frame_num <= (final_q && op_q == OP_FRAME) ? 8'd0 : frame_num + 8'd1;
              step      <= step + 2'd1;
            end else begin
              idx <= idx + FILL_W'(1);
            end
          end
        end
        ST_FAULT: begin
        end
      endcase
    end
  end

  `TRF_ASSERT(a_emit_room, emit.valid |-> can_emit, "item emitted into a full output register")
  `TRF_ASSERT(a_close_rewind, (state == ST_CLOSE && can_emit && last_word) |=> (fill == FILL_W'(HDR_WORDS)), "fill not rewound after record close")
  `TRF_ASSERT(a_fault_lone, (emit.valid && emit.fault) |-> (emit.eorun && !emit.eor && emit.word == 32'h0), "fault item not a lone zero word")
  `TRF_ASSERT_NEVER(a_accept_busy, in_ready && state != ST_IDLE, "item accepted while sequencer busy")

endmodule

`default_nettype wire
